// ===== design/pfdw_pkg.sv =====
// Shared types and constants of the paged framebuffer dirty window unit.
`default_nettype none
package pfdw_pkg;

    localparam int ScreenColumns = 128;
    localparam int ScreenPages   = 8;
    localparam int SourceStride  = 16;
    localparam int ScreenRows    = ScreenPages * 8;

    localparam int COL_W  = $clog2(ScreenColumns);
    localparam int PAGE_W = $clog2(ScreenPages);
    localparam int ROW_W  = $clog2(ScreenRows);
    localparam int SRC_W  = $clog2(SourceStride);
    localparam int ADDR_W = PAGE_W + COL_W;
    localparam int DEPTH  = ScreenColumns * ScreenPages;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_BEGIN_BLIT = 2'd0,
        OP_BLIT_BYTE  = 2'd1,
        OP_DIRTY_READ = 2'd2,
        OP_FULL_READ  = 2'd3
    } t_op;

    // One classified request as it waits in the queue.
    typedef struct packed {
        t_op              op;
        logic             blit_ok;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [4:0]       w;
        logic [COL_W-1:0] right;
        logic [ROW_W-1:0] bottom;
        logic [7:0]       data;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/paged_framebuffer_dirty_window_unit.sv =====
// Top level of the paged framebuffer dirty window unit.
// The unit keeps a 128 by 8 page monochrome store and a dirty window.
// Requests arrive on the slave stream: tuser carries the operation (begin
// blit, blit byte, dirty readout step, full readout step) and tdata the
// blit rectangle and source byte. Each readout step that finds data gives
// one result on the master stream: tdata holds the byte, its column and
// page, and tlast marks the final byte of the region read.
// Requests pass a two-entry queue to the back end. A blit request is handled
// in the idle state; a readout step goes through a memory read, then the result
// register load and clearing write, so a readout request passes the queue, the
// read data register and the result register before its result is valid.
// After reset the store is cleared one byte per cycle, and no request is
// accepted until that pass ends.
// When the receiver stalls, the result register holds its byte, the back
// end waits on the next readout step, and the queue then fills and drops
// tready.
`default_nettype none
module paged_framebuffer_dirty_window_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // x_pos[6:0], y_pos[12:7], blit_width[17:13], blit_height[22:18],
    // source_byte[30:23], zero pad
    input  wire logic [pfdw_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // operation[1:0]
    input  wire logic [1:0]                      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // pixel_byte[7:0], out_column[14:8], out_page[17:15], zero pad
    output logic [pfdw_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast
);
    import pfdw_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_ready;
    logic queue_valid;
    logic back_ready;
    logic clearing;

    assign o_s_tready = queue_ready && !clearing;

    pfdw_front u_front (
        .i_op   (i_s_tuser),
        .i_data (i_s_tdata),
        .o_cmd  (front_cmd)
    );

    pfdw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_tvalid && !clearing),
        .o_wr_ready (queue_ready),
        .i_wr_data  (front_cmd),
        .o_rd_valid (queue_valid),
        .i_rd_ready (back_ready),
        .o_rd_data  (queue_cmd)
    );

    pfdw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (back_ready),
        .o_clearing  (clearing),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
`default_nettype wire

// ===== design/pfdw_front.sv =====
// Front part: decodes a request and clips a blit rectangle to the screen and its width to the source stride.
`default_nettype none
module pfdw_front (
    input  wire logic [1:0]                     i_op,
    input  wire logic [pfdw_pkg::IN_DATA_W-1:0] i_data,
    output pfdw_pkg::t_cmd                      o_cmd
);
    import pfdw_pkg::*;

    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [4:0]       w_in;
    logic [4:0]       h_in;
    logic [COL_W:0]   col_room;
    logic [ROW_W:0]   row_room;
    logic [COL_W:0]   w_clip;
    logic [ROW_W:0]   h_clip;

    always_comb begin
        x        = i_data[6:0];
        y        = i_data[12:7];
        w_in     = i_data[17:13];
        h_in     = i_data[22:18];
        col_room = (COL_W+1)'(ScreenColumns) - {1'b0, x};
        row_room = (ROW_W+1)'(ScreenRows) - {1'b0, y};
        w_clip   = (COL_W+1)'(w_in);
        if (w_clip > col_room) begin
            w_clip = col_room;
        end
        if (w_clip > (COL_W+1)'(SourceStride)) begin
            w_clip = (COL_W+1)'(SourceStride);
        end
        h_clip = (ROW_W+1)'(h_in);
        if (h_clip > row_room) begin
            h_clip = row_room;
        end
        o_cmd.op      = t_op'(i_op);
        o_cmd.blit_ok = (w_clip != '0) && (h_clip != '0);
        o_cmd.x       = x;
        o_cmd.y       = y;
        o_cmd.w       = w_clip[4:0];
        o_cmd.right   = COL_W'(x + w_clip[COL_W-1:0] - COL_W'(1));
        o_cmd.bottom  = ROW_W'(y + h_clip[ROW_W-1:0] - ROW_W'(1));
        o_cmd.data    = i_data[30:23];
    end

endmodule
`default_nettype wire

// ===== design/pfdw_queue.sv =====
// Two-entry request queue between the front and back parts.
`default_nettype none
module pfdw_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_valid,
    output logic                o_wr_ready,
    input  wire pfdw_pkg::t_cmd i_wr_data,
    output logic                o_rd_valid,
    input  wire logic           i_rd_ready,
    output pfdw_pkg::t_cmd      o_rd_data
);
    import pfdw_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/pfdw_back.sv =====
// Back part: frame store, blit and dirty window state, readout and result register.
`default_nettype none
module pfdw_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pfdw_pkg::t_cmd                  i_cmd,
    input  wire logic                            i_cmd_valid,
    output logic                                 o_cmd_ready,
    output logic                                 o_clearing,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [pfdw_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic                                 o_m_tlast
);
    import pfdw_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ} t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [7:0]          r_mem [DEPTH];
    logic [7:0]          r_rd_data;

    logic [7:0]          r_left, r_top, r_right, r_bottom;
    logic [COL_W-1:0]    r_origin;
    logic [4:0]          r_width;
    logic [SRC_W-1:0]    r_src;
    logic [PAGE_W-1:0]   r_cur_page;
    logic [PAGE_W-1:0]   r_end_page;
    logic                r_blit_active;
    logic [COL_W-1:0]    r_col;
    logic [PAGE_W-1:0]   r_page;
    logic                r_ro_active;

    logic [ADDR_W-1:0]   r_pend_addr;
    logic [COL_W-1:0]    r_pend_col;
    logic [PAGE_W-1:0]   r_pend_page;
    logic                r_pend_last;

    logic                r_m_valid;
    logic [7:0]          r_m_byte;
    logic [COL_W-1:0]    r_m_col;
    logic [PAGE_W-1:0]   r_m_page;
    logic                r_m_last;

    logic                take;
    logic                full;
    logic                empty;
    logic [COL_W-1:0]    rl, rr, cc;
    logic [PAGE_W-1:0]   fp, lp, cp;
    logic                last;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic                out_free;
    logic [COL_W-1:0]    blit_col;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_clearing  = (r_state == S_CLEAR);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tlast   = r_m_last;
    assign o_m_tdata   = {6'd0, r_m_page, r_m_col, r_m_byte};

    // Region and position of a readout step.
    always_comb begin
        full  = (i_cmd.op == OP_FULL_READ);
        empty = !full && ((r_top > r_bottom) || (r_left > r_right));
        rl    = full ? '0 : r_left[COL_W-1:0];
        rr    = full ? COL_W'(ScreenColumns - 1) : r_right[COL_W-1:0];
        fp    = full ? '0 : r_top[ROW_W-1:3];
        lp    = full ? PAGE_W'(ScreenPages - 1) : r_bottom[ROW_W-1:3];
        cc    = r_ro_active ? r_col : rl;
        cp    = r_ro_active ? r_page : fp;
        last  = (cp == lp) && (cc == rr);
        blit_col = r_origin + COL_W'(r_src);
    end

    // Single write port, shared by clearing, blits and read-clear.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = 8'd0;
        rd_en   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
            end
            S_IDLE: begin
                if (take && i_cmd.op == OP_BLIT_BYTE && r_blit_active
                    && ({1'b0, r_src} < r_width)) begin
                    wr_en   = 1'b1;
                    wr_addr = {r_cur_page, blit_col};
                    wr_data = i_cmd.data;
                end
                rd_en = take && (i_cmd.op == OP_DIRTY_READ || i_cmd.op == OP_FULL_READ)
                        && !empty;
            end
            S_READ: begin
                wr_en = out_free;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[{cp, cc}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_left        <= 8'd255;
            r_top         <= 8'd255;
            r_right       <= 8'd0;
            r_bottom      <= 8'd0;
            r_origin      <= '0;
            r_width       <= '0;
            r_src         <= '0;
            r_cur_page    <= '0;
            r_end_page    <= '0;
            r_blit_active <= 1'b0;
            r_col         <= '0;
            r_page        <= '0;
            r_ro_active   <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        case (i_cmd.op)
                            OP_BEGIN_BLIT: begin
                                r_blit_active <= i_cmd.blit_ok;
                                if (i_cmd.blit_ok) begin
                                    r_origin   <= i_cmd.x;
                                    r_width    <= i_cmd.w;
                                    r_src      <= '0;
                                    r_cur_page <= i_cmd.y[ROW_W-1:3];
                                    r_end_page <= i_cmd.bottom[ROW_W-1:3];
                                    if (r_left > 8'(i_cmd.x)) r_left <= 8'(i_cmd.x);
                                    if (r_top > 8'(i_cmd.y)) r_top <= 8'(i_cmd.y);
                                    if (r_right < 8'(i_cmd.right)) begin
                                        r_right <= 8'(i_cmd.right);
                                    end
                                    if (r_bottom < 8'(i_cmd.bottom)) begin
                                        r_bottom <= 8'(i_cmd.bottom);
                                    end
                                end
                            end
                            OP_BLIT_BYTE: begin
                                if (r_blit_active) begin
                                    if (r_src == SRC_W'(SourceStride - 1)) begin
                                        r_src <= '0;
                                        if (r_cur_page >= r_end_page) begin
                                            r_blit_active <= 1'b0;
                                        end else begin
                                            r_cur_page <= r_cur_page + PAGE_W'(1);
                                        end
                                    end else begin
                                        r_src <= r_src + SRC_W'(1);
                                    end
                                end
                            end
                            default: begin
                                if (empty) begin
                                    r_left      <= 8'd255;
                                    r_top       <= 8'd255;
                                    r_right     <= 8'd0;
                                    r_bottom    <= 8'd0;
                                    r_ro_active <= 1'b0;
                                end else begin
                                    r_pend_addr <= {cp, cc};
                                    r_pend_col  <= cc;
                                    r_pend_page <= cp;
                                    r_pend_last <= last;
                                    r_state     <= S_READ;
                                    if (last) begin
                                        r_ro_active <= 1'b0;
                                        r_left      <= 8'd255;
                                        r_top       <= 8'd255;
                                        r_right     <= 8'd0;
                                        r_bottom    <= 8'd0;
                                    end else if (cc >= rr
                                                 || cc == COL_W'(ScreenColumns - 1)) begin
                                        r_ro_active <= 1'b1;
                                        r_col       <= rl;
                                        r_page      <= (cp == PAGE_W'(ScreenPages - 1))
                                                       ? '0 : cp + PAGE_W'(1);
                                    end else begin
                                        r_ro_active <= 1'b1;
                                        r_col       <= cc + COL_W'(1);
                                        r_page      <= cp;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // The byte is handed on and cleared in the same cycle.
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && out_free) begin
            r_m_byte <= r_rd_data;
            r_m_col  <= r_pend_col;
            r_m_page <= r_pend_page;
            r_m_last <= r_pend_last;
        end
    end

endmodule
`default_nettype wire

// ===== tb/paged_framebuffer_dirty_window_unit_tb.sv =====
// Self-checking testbench of the paged framebuffer dirty window unit.
`timescale 1ns / 100ps
`default_nettype none
module paged_framebuffer_dirty_window_unit_tb;
    import pfdw_pkg::*;

    typedef struct packed {
        logic [7:0] pixel;
        logic [6:0] column;
        logic [2:0] page;
        logic       last;
    } t_pixel_out;

    typedef struct {
        t_op        op;
        logic [6:0] x;
        logic [5:0] y;
        logic [4:0] w;
        logic [4:0] h;
        logic [7:0] data;
        logic       has_exp;
        t_pixel_out exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] i_s_tdata = '0;
    logic [1:0] i_s_tuser = '0;
    logic i_m_tready = 1'b0;
    logic o_s_tready, o_m_tvalid, o_m_tlast;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    paged_framebuffer_dirty_window_unit DUT (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [7:0] pix_mem [1024];
    int unsigned win_l, win_t, win_r, win_b;
    int unsigned bl_org, bl_w, bl_src, bl_page, bl_end;
    bit bl_on;
    int unsigned rd_col, rd_page;
    bit rd_on;

    t_pixel_out pixel_q [$];
    t_row rows [$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    task automatic window_clear();
        win_l = 255; win_t = 255; win_r = 0; win_b = 0;
    endtask

    // Advances the predicted state by one request and queues any byte out.
    task automatic predict_frame(input t_row r);
        int unsigned x, y, w, h, lft, rgt, fp, lp, idx;
        t_pixel_out o;
        x = r.x; y = r.y; w = r.w; h = r.h;
        case (r.op)
            OP_BEGIN_BLIT: begin
                bl_on = 0;
                if (x < 128 && y < 64) begin
                    if (w > 128 - x) w = 128 - x;
                    if (w > 16) w = 16;
                    if (h > 64 - y) h = 64 - y;
                    if (w != 0 && h != 0) begin
                        bl_org = x; bl_w = w; bl_src = 0;
                        bl_page = y >> 3; bl_end = (y + h - 1) >> 3; bl_on = 1;
                        if (win_l > x) win_l = x;
                        if (win_t > y) win_t = y;
                        if (win_r < x + w - 1) win_r = x + w - 1;
                        if (win_b < y + h - 1) win_b = y + h - 1;
                    end
                end
            end
            OP_BLIT_BYTE: begin
                if (bl_on) begin
                    if (bl_src < bl_w) begin
                        idx = bl_page * 128 + bl_org + bl_src;
                        if (idx < 1024) pix_mem[idx] = r.data;
                    end
                    if (bl_src + 1 >= 16) begin
                        bl_src = 0;
                        if (bl_page >= bl_end) bl_on = 0;
                        else bl_page++;
                    end else bl_src++;
                end
            end
            default: begin
                if (r.op == OP_FULL_READ) begin
                    lft = 0; rgt = 127; fp = 0; lp = 7;
                end else if (win_t > win_b || win_l > win_r) begin
                    window_clear();
                    rd_on = 0;
                    return;
                end else begin
                    lft = win_l; rgt = win_r; fp = win_t >> 3; lp = win_b >> 3;
                end
                if (!rd_on) begin
                    rd_col = lft; rd_page = fp; rd_on = 1;
                end
                idx = rd_page * 128 + rd_col;
                o.pixel = 0;
                if (rd_col < 128 && idx < 1024) begin
                    o.pixel = pix_mem[idx];
                    pix_mem[idx] = 0;
                end
                o.last = (rd_page == lp) && (rd_col == rgt);
                o.column = rd_col[6:0];
                o.page = rd_page[2:0];
                if (r.has_exp && o != r.exp) begin
                    $error({"table entry: expected byte %0h col %0d page %0d last %0b, ",
                            "model gives byte %0h col %0d page %0d last %0b"},
                           r.exp.pixel, r.exp.column, r.exp.page, r.exp.last,
                           o.pixel, o.column, o.page, o.last);
                    errors++;
                end
                pixel_q.push_back(o);
                if (o.last) begin
                    rd_on = 0;
                    window_clear();
                end else if (rd_col >= rgt || rd_col >= 127) begin
                    rd_col = lft;
                    rd_page++;
                    if (rd_page >= 8) rd_page = 0;
                end else rd_col++;
            end
        endcase
    endtask

    function automatic t_row mk(t_op op, int x, int y, int w, int h, int d);
        t_row r;
        r.op = op; r.x = 7'(x); r.y = 6'(y); r.w = 5'(w); r.h = 5'(h); r.data = 8'(d);
        r.has_exp = 0;
        r.exp = '{default: '0};
        return r;
    endfunction

    function automatic t_row mk_read(t_op op, int px, int c, int p, int l);
        t_row r;
        r = mk(op, 0, 0, 0, 0, 0);
        r.has_exp = 1;
        r.exp = '{pixel: 8'(px), column: 7'(c), page: 3'(p), last: l[0]};
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int k;
        k = $urandom_range(0, 99);
        r = mk(OP_BLIT_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (k < 8) begin
            r.op = OP_BEGIN_BLIT;
            // Mostly small in-screen rectangles; raw fields now and then.
            if ($urandom_range(0, 3) != 0) begin
                r.w = 5'($urandom_range(1, 16));
                r.h = 5'($urandom_range(1, 16));
            end
        end else if (k < 60) r.op = OP_BLIT_BYTE;
        else if (k < 90) r.op = OP_DIRTY_READ;
        else r.op = OP_FULL_READ;
        return r;
    endfunction

    // Request sender.
    initial begin
        t_row r;
        int g;
        for (int i = 0; i < 1024; i++) pix_mem[i] = 0;
        window_clear();
        bl_org = 0; bl_w = 0; bl_src = 0; bl_page = 0; bl_end = 0; bl_on = 0;
        rd_col = 0; rd_page = 0; rd_on = 0;

        // Directed table.
        rows.push_back(mk_read(OP_FULL_READ, 0, 0, 0, 0));
        rows.push_back(mk(OP_DIRTY_READ, 0, 0, 0, 0, 0));       // empty window
        rows.push_back(mk(OP_BLIT_BYTE, 0, 0, 0, 0, 8'hff));    // stray byte
        rows.push_back(mk(OP_BEGIN_BLIT, 127, 63, 0, 0, 0));    // empty blit
        rows.push_back(mk(OP_BEGIN_BLIT, 127, 63, 31, 31, 0));  // clipped to 1x1
        rows.push_back(mk(OP_BLIT_BYTE, 0, 0, 0, 0, 8'hff));
        rows.push_back(mk(OP_DIRTY_READ, 0, 0, 0, 0, 0));
        rows.push_back(mk(OP_BEGIN_BLIT, 0, 0, 16, 16, 0));
        rows.push_back(mk(OP_BEGIN_BLIT, 5, 9, 3, 1, 0));       // restart
        rows.push_back(mk(OP_BLIT_BYTE, 0, 0, 0, 0, 8'h81));
        rows.push_back(mk(OP_BLIT_BYTE, 0, 0, 0, 0, 8'h00));
        rows.push_back(mk(OP_BLIT_BYTE, 0, 0, 0, 0, 8'h5a));
        rows.push_back(mk(OP_BLIT_BYTE, 0, 0, 0, 0, 8'ha5));    // dropped
        rows.push_back(mk(OP_DIRTY_READ, 0, 0, 0, 0, 0));
        rows.push_back(mk(OP_DIRTY_READ, 0, 0, 0, 0, 0));
        rows.push_back(mk(OP_BEGIN_BLIT, 120, 60, 16, 16, 0));  // grows window
        rows.push_back(mk(OP_DIRTY_READ, 0, 0, 0, 0, 0));
        rows.push_back(mk(OP_FULL_READ, 0, 0, 0, 0, 0));        // mixed readout
        rows.push_back(mk(OP_BEGIN_BLIT, 0, 0, 16, 16, 0));
        for (int i = 0; i < 1300; i++) rows.push_back(rand_row());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[n]) begin
            r = rows[n];
            i_s_tvalid <= 1'b1;
            i_s_tuser <= r.op;
            i_s_tdata <= {1'b0, r.data, r.h, r.w, r.y, r.x};
            do @(posedge i_clk); while (!o_s_tready);
            predict_frame(r);
            if (n == 600) hold_off = 1'b1;
            g = (n < 20) ? 0 : gap_len();
            if (g != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver back-pressure.
    initial begin
        int g;
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g == 0) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_pixel_out e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected result byte %0h", o_m_tdata[7:0]);
                errors++;
            end else begin
                e = pixel_q.pop_front();
                if (o_m_tdata[7:0] !== e.pixel) begin
                    $error("pixel_byte expected %0h actual %0h", e.pixel, o_m_tdata[7:0]);
                    errors++;
                end
                if (o_m_tdata[14:8] !== e.column) begin
                    $error("out_column expected %0d actual %0d", e.column, o_m_tdata[14:8]);
                    errors++;
                end
                if (o_m_tdata[17:15] !== e.page) begin
                    $error("out_page expected %0d actual %0d", e.page, o_m_tdata[17:15]);
                    errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last_of_run expected %0b actual %0b", e.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Run control and timeout.
    initial begin
        fork
            begin
                wait (stim_done);
                while (pixel_q.size() != 0) @(posedge i_clk);
                repeat (50) @(posedge i_clk);
                if (pixel_q.size() != 0) errors++;
                if (errors == 0) begin
                    $display("Simulation PASSED");
                end else begin
                    $display("Simulation FAILED");
                end
            end
            begin
                while (cycles < 200000) begin
                    @(posedge i_clk);
                    cycles++;
                end
                $display("Simulation FAILED");
            end
        join_any
        $finish;
    end
endmodule
`default_nettype wire

// ===== paged_framebuffer_dirty_window_unit.f =====
design/pfdw_pkg.sv
design/pfdw_front.sv
design/pfdw_queue.sv
design/pfdw_back.sv
design/paged_framebuffer_dirty_window_unit.sv
tb/paged_framebuffer_dirty_window_unit_tb.sv
